@@ src/utf8d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and helpers for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int CP_W    = 21;
  localparam int CLS_W   = 2;
  localparam int PEND_W  = 2;

  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

  // character class codes
  localparam logic [CLS_W-1:0] CLS_ASCII = 2'd0;
  localparam logic [CLS_W-1:0] CLS_CJK   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_OTHER = 2'd2;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [CLS_W-1:0] char_class;
    logic             malformed;
    logic             last_of_run;
  } res_t;

  // decode outcome for one byte
  typedef struct packed {
    logic [1:0]        cnt;      // results made, 0..2
    res_t              r0;
    res_t              r1;
    logic [CP_W-1:0]   partial;
    logic [PEND_W-1:0] pending;
  } dec_t;

  function automatic logic [CLS_W-1:0] classify(input logic [CP_W-1:0] cp);
    logic [CLS_W-1:0] cls;
    cls = CLS_OTHER;
    if (cp <= 21'h00007F) begin
      cls = CLS_ASCII;
    end else if ((cp >= 21'h002E80 && cp <= 21'h009FFF) ||
                 (cp >= 21'h00F900 && cp <= 21'h00FAFF) ||
                 (cp >= 21'h00FE30 && cp <= 21'h00FE4F) ||
                 (cp >= 21'h00FF00 && cp <= 21'h00FFEF)) begin
      cls = CLS_CJK;
    end
    return cls;
  endfunction

  function automatic res_t make_res(input logic [CP_W-1:0] cp, input logic bad,
                                    input logic last);
    res_t r;
    r.code_point  = cp;
    r.char_class  = classify(cp);
    r.malformed   = bad;
    r.last_of_run = last;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/utf8d_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_decode
// Combinational decode of one byte against the partial character state.
// ----------------------------------------------------------------------------
module utf8d_decode (
  input  logic [7:0]                      text_byte,
  input  logic [utf8d_pkg::CP_W-1:0]      partial,
  input  logic [utf8d_pkg::PEND_W-1:0]    pending,
  output utf8d_pkg::dec_t                 dec
);
  import utf8d_pkg::*;

  logic [CP_W-1:0]   lead_base;
  logic [CP_W-1:0]   lead_partial;
  logic [PEND_W-1:0] lead_pending;
  logic              lead_emit;
  logic              lead_bad;
  logic [CP_W-1:0]   lead_cp;
  logic [CP_W-1:0]   acc;

  // byte taken as a lead; a bad continuation drops the partial first
  always_comb begin
    lead_base    = (pending == '0) ? partial : '0;
    lead_partial = lead_base;
    lead_pending = '0;
    lead_emit    = 1'b1;
    lead_bad     = 1'b0;
    lead_cp      = {13'd0, text_byte};
    if (!text_byte[7]) begin
      lead_emit = 1'b1;
    end else if (text_byte[7:5] == 3'b110) begin
      lead_partial = {16'd0, text_byte[4:0]};
      lead_pending = 2'd1;
      lead_emit    = 1'b0;
    end else if (text_byte[7:4] == 4'b1110) begin
      lead_partial = {17'd0, text_byte[3:0]};
      lead_pending = 2'd2;
      lead_emit    = 1'b0;
    end else if (text_byte[7:3] == 5'b11110) begin
      lead_partial = {18'd0, text_byte[2:0]};
      lead_pending = 2'd3;
      lead_emit    = 1'b0;
    end else begin
      lead_cp  = CP_REPLACEMENT;
      lead_bad = 1'b1;
    end
  end

  assign acc = {partial[14:0], text_byte[5:0]};

  always_comb begin
    dec.cnt     = 2'd0;
    dec.r0      = '0;
    dec.r1      = '0;
    dec.partial = partial;
    dec.pending = pending;
    if (pending == '0) begin
      dec.partial = lead_partial;
      dec.pending = lead_pending;
      if (lead_emit) begin
        dec.cnt = 2'd1;
        dec.r0  = make_res(lead_cp, lead_bad, 1'b1);
      end
    end else if (text_byte[7:6] == 2'b10) begin
      dec.partial = acc;
      dec.pending = pending - 2'd1;
      if (pending == 2'd1) begin
        dec.cnt = 2'd1;
        dec.r0  = make_res(acc, 1'b0, 1'b1);
      end
    end else begin
      dec.partial = lead_partial;
      dec.pending = lead_pending;
      dec.r0      = make_res(CP_REPLACEMENT, 1'b1, !lead_emit);
      if (lead_emit) begin
        dec.cnt = 2'd2;
        dec.r1  = make_res(lead_cp, lead_bad, 1'b1);
      end else begin
        dec.cnt = 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/utf8d_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_outq
// Four-entry result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module utf8d_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_cnt,
  input  utf8d_pkg::res_t      push_r0,
  input  utf8d_pkg::res_t      push_r1,
  input  logic                 pop,
  output utf8d_pkg::res_t      head,
  output logic                 not_empty,
  output logic                 room2
);
  import utf8d_pkg::*;

  res_t       q_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign head      = q_r[rd_ptr_r];
  assign not_empty = (cnt_r != 3'd0);
  assign room2     = (cnt_r <= 3'd2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    cnt_nxt    = cnt_r + {1'b0, push_cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_r[wr_ptr_r] <= push_r0;
    end
    if (push_cnt == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= push_r1;
    end
  end

endmodule
`default_nettype wire

@@ src/utf8_decoder_with_cjk_class.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_decoder_with_cjk_class
// UTF-8 byte stream decoder; each result carries a code point and a class.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready   | in_text_byte[7:0]
//  out     | output    | out_valid/out_ready | out_code_point[20:0], out_char_class[1:0],
//          |           |                     | out_malformed, out_last_of_run
//
//  One byte per cycle while in_ready is high. A byte waits in the input
//  register, is decoded and lands in the result queue, whose head shows on
//  the outputs. A byte that gives two results costs two output slots,
//  so the queue's single pop port sets the rate for such bytes.
//  Synchronous active-low reset clears decode state, input and queue.
//  in_ready drops only while the input register holds a byte that the
//  queue (fewer than two free entries) cannot yet take.
// ----------------------------------------------------------------------------
module utf8_decoder_with_cjk_class (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_text_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [utf8d_pkg::CP_W-1:0]     out_code_point,
  output logic [utf8d_pkg::CLS_W-1:0]    out_char_class,
  output logic                           out_malformed,
  output logic                           out_last_of_run
);
  import utf8d_pkg::*;

  // input register
  logic [7:0]        byte_r;
  logic              full_r, full_nxt;

  // decode state: partial code point and continuation bytes still due
  logic [CP_W-1:0]   partial_r;
  logic [PEND_W-1:0] pending_r;

  dec_t              dec;
  res_t              head;
  logic              room2;
  logic              fire;
  logic              in_take;

  // decode only when the queue has room for the worst case of two results
  assign fire     = full_r & room2;
  assign in_ready = !full_r | fire;
  assign in_take  = in_valid & in_ready;

  always_comb begin
    full_nxt = full_r;
    if (in_take) begin
      full_nxt = 1'b1;
    end else if (fire) begin
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r    <= 1'b0;
      partial_r <= '0;
      pending_r <= '0;
    end else begin
      full_r <= full_nxt;
      if (fire) begin
        partial_r <= dec.partial;
        pending_r <= dec.pending;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_text_byte;
    end
  end

  utf8d_decode u_decode (
    .text_byte (byte_r),
    .partial   (partial_r),
    .pending   (pending_r),
    .dec       (dec)
  );

  utf8d_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (fire ? dec.cnt : 2'd0),
    .push_r0   (dec.r0),
    .push_r1   (dec.r1),
    .pop       (out_valid & out_ready),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign out_code_point  = head.code_point;
  assign out_char_class  = head.char_class;
  assign out_malformed   = head.malformed;
  assign out_last_of_run = head.last_of_run;

endmodule
`default_nettype wire

@@ src/utf8d_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks for the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     in_text_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [utf8d_pkg::CP_W-1:0]     out_code_point,
  input  logic [utf8d_pkg::CLS_W-1:0]    out_char_class,
  input  logic                           out_malformed,
  input  logic                           out_last_of_run
);
  import utf8d_pkg::*;

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point)
      && $stable(out_malformed) && $stable(out_last_of_run))
    else $error("result item changed while stalled");

  // replacement is always classed as other
  a_bad_repl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_malformed |->
      out_code_point == CP_REPLACEMENT && out_char_class == CLS_OTHER)
    else $error("malformed item not a classed replacement");

  // ASCII range, including end-of-text, is never malformed
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_code_point <= 21'h00007F |->
      out_char_class == CLS_ASCII && !out_malformed)
    else $error("ASCII item misclassed");

  // a non-final replacement is followed by the second result of its byte
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("second result of a byte missing");

endmodule

bind utf8_decoder_with_cjk_class utf8d_checker u_chk (.*);
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Bench for utf8_decoder_with_cjk_class. A byte-level decoder model predicts
// every char result (code point, class, malformed flag, last-of-run flag)
// for each accepted byte. Observed results are matched in order against the
// predicted ones. Stimulus starts with hand-picked sequences, then moves to
// random well-formed chars mixed with broken sequences and stray bytes.
// Sender and receiver idle at random, but for a last phase at full rate.
// ----------------------------------------------------------------------------
module testbench;
  import utf8d_pkg::*;

  // --------------------------------------------------------------------------
  // Decoder model and store of chars still due from the block
  // --------------------------------------------------------------------------
  class char_expectations;
    res_t            due_chars[$];  // predicted results, oldest first
    res_t            fresh[$];      // results made by the current byte
    logic [CP_W-1:0] part_cp;       // code point bits gathered so far
    logic [1:0]      cont_left;     // continuation bytes still owed
    int              mismatches;

    function new();
      part_cp    = '0;
      cont_left  = '0;
      mismatches = 0;
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
    endtask

    function logic [CLS_W-1:0] class_of(input logic [CP_W-1:0] cp);
      if (cp <= 21'h7F)
        return CLS_ASCII;
      if ((cp >= 21'h2E80 && cp <= 21'h9FFF) || (cp >= 21'hF900 && cp <= 21'hFAFF) ||
          (cp >= 21'hFE30 && cp <= 21'hFE4F) || (cp >= 21'hFF00 && cp <= 21'hFFEF))
        return CLS_CJK;
      return CLS_OTHER;
    endfunction

    function void emit(input logic [CP_W-1:0] cp, input logic bad);
      res_t r;
      r.code_point  = cp;
      r.char_class  = class_of(cp);
      r.malformed   = bad;
      r.last_of_run = 1'b0;
      fresh.push_back(r);
    endfunction

    // byte seen while no continuation is owed
    function void take_lead(input logic [7:0] b);
      if (!b[7]) begin
        emit({13'd0, b}, 1'b0);
      end else if (b[7:5] == 3'b110) begin
        part_cp   = {16'd0, b[4:0]};
        cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        part_cp   = {17'd0, b[3:0]};
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        part_cp   = {18'd0, b[2:0]};
        cont_left = 2'd3;
      end else begin
        emit(CP_REPLACEMENT, 1'b1);
      end
    endfunction

    // accepted byte: work out what the block owes for it
    function void note_byte(input logic [7:0] b);
      res_t r;
      fresh.delete();
      if (cont_left == 2'd0) begin
        take_lead(b);
      end else if (b[7:6] == 2'b10) begin
        part_cp   = {part_cp[CP_W-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0)
          emit(part_cp, 1'b0);
      end else begin
        // broken sequence: replacement, then the byte again as a lead
        part_cp   = '0;
        cont_left = '0;
        emit(CP_REPLACEMENT, 1'b1);
        take_lead(b);
      end
      if (fresh.size() > 0) begin
        r = fresh.pop_back();
        r.last_of_run = 1'b1;
        fresh.push_back(r);
      end
      foreach (fresh[i])
        due_chars.push_back(fresh[i]);
    endfunction

    task check_char(input logic [CP_W-1:0] cp, input logic [CLS_W-1:0] cls,
                    input logic bad, input logic fin);
      res_t want;
      if (due_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected result cp=%h", cp));
      end else begin
        want = due_chars.pop_front();
        if (cp !== want.code_point)
          report_mismatch($sformatf("code_point %h, want %h", cp, want.code_point));
        if (cls !== want.char_class)
          report_mismatch($sformatf("char_class %0d, want %0d (cp %h)",
                                    cls, want.char_class, want.code_point));
        if (bad !== want.malformed)
          report_mismatch($sformatf("malformed %b, want %b (cp %h)",
                                    bad, want.malformed, want.code_point));
        if (fin !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %b, want %b (cp %h)",
                                    fin, want.last_of_run, want.code_point));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic [7:0]        in_text_byte = 8'h00;
  logic              out_ready    = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [CP_W-1:0]   out_code_point;
  logic [CLS_W-1:0]  out_char_class;
  logic              out_malformed;
  logic              out_last_of_run;

  always #5 clk = ~clk;

  utf8_decoder_with_cjk_class dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_char_class  (out_char_class),
    .out_malformed   (out_malformed),
    .out_last_of_run (out_last_of_run)
  );

  char_expectations book = new();

  // idle rates in percent, changed per phase by the main sequence
  int   tx_idle_pct = 23;
  int   rx_idle_pct = 60;
  // long receiver hold: requested by the main sequence, timed below
  logic rx_hold_req = 1'b0;
  int   rx_hold_left = 0;

  // --------------------------------------------------------------------------
  // Receiver: checks every accepted item, then picks next cycle's ready.
  // Reads happen at the edge, before the DUT's registers settle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      book.check_char(out_code_point, out_char_class, out_malformed, out_last_of_run);
    if (rx_hold_req) begin
      rx_hold_left = 300;
      rx_hold_req <= 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one byte and hold it until taken. A gap lowers valid first and
  // always lets a clock edge pass with valid low, so valid is never dropped and
  // raised in the same step.
  task send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (!in_ready);
    book.note_byte(b);
  endtask

  // stop offering and wait until the block has delivered everything owed
  task wait_all_delivered();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.due_chars.size() != 0) @(posedge clk);
  endtask

  // UTF-8 bytes of a code point, in the given length (no overlong checks
  // in the block, so any value that fits is fair game)
  task send_char(input logic [CP_W-1:0] cp, input int len);
    case (len)
      1: begin
        send_byte({1'b0, cp[6:0]});
      end
      2: begin
        send_byte({3'b110, cp[10:6]});
        send_byte({2'b10, cp[5:0]});
      end
      3: begin
        send_byte({4'b1110, cp[15:12]});
        send_byte({2'b10, cp[11:6]});
        send_byte({2'b10, cp[5:0]});
      end
      default: begin
        send_byte({5'b11110, cp[20:18]});
        send_byte({2'b10, cp[17:12]});
        send_byte({2'b10, cp[11:6]});
        send_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // three-byte code point aimed at the class borders and CJK blocks
  function automatic logic [CP_W-1:0] pick_cjk_side();
    logic [CP_W-1:0] edges[12] = '{21'h2E7F, 21'h2E80, 21'h9FFF, 21'hA000,
                                   21'hF8FF, 21'hF900, 21'hFAFF, 21'hFE2F,
                                   21'hFE50, 21'hFEFF, 21'hFFEF, 21'hFFF0};
    case ($urandom_range(0, 4))
      0: return edges[$urandom_range(0, 11)];
      1: return CP_W'($urandom_range(21'h2E80, 21'h9FFF));
      2: return CP_W'($urandom_range(21'hF900, 21'hFAFF));
      3: return CP_W'($urandom_range(21'hFE30, 21'hFE4F));
      default: return CP_W'($urandom_range(21'hFF00, 21'hFFEF));
    endcase
  endfunction

  // Mostly whole chars with random content; the rest are cut-short
  // sequences and stray bytes.
  task send_random_chars(input int count);
    int kind;
    int len;
    int cut;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
        send_char((kind == 0) ? 21'd0 : CP_W'($urandom_range(1, 21'h7F)), 1);
      end else if (kind < 46) begin
        send_char(CP_W'($urandom_range(0, 21'h7FF)), 2);
      end else if (kind < 60) begin
        send_char(pick_cjk_side(), 3);
      end else if (kind < 70) begin
        send_char(CP_W'($urandom_range(0, 21'hFFFF)), 3);
      end else if (kind < 80) begin
        send_char(CP_W'($urandom_range(0, 21'h1FFFFF)), 4);
      end else if (kind < 90) begin
        // lead, too few continuations, then a byte that is no continuation
        len = $urandom_range(2, 4);
        cut = $urandom_range(0, len - 2);
        case (len)
          2: send_byte({3'b110, 5'($urandom)});
          3: send_byte({4'b1110, 4'($urandom)});
          default: send_byte({5'b11110, 3'($urandom)});
        endcase
        for (int k = 0; k < cut; k++)
          send_byte({2'b10, 6'($urandom)});
        send_byte($urandom_range(0, 1) ? {1'b0, 7'($urandom)} : {2'b11, 6'($urandom)});
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // end of text, ASCII top, 2/3/4-byte chars, invalid leads, broken runs
    logic [7:0] directed[26];
    directed = '{
      8'h00, 8'h7F,                       // end of text, top ASCII
      8'hC3, 8'hA9,                       // U+00E9
      8'hE4, 8'hB8, 8'hAD,                // U+4E2D, CJK
      8'hEF, 8'hBC, 8'h81,                // U+FF01, full-width
      8'hF7, 8'hBF, 8'hBF, 8'hBF,         // largest 21-bit value
      8'h80, 8'hBF, 8'hF8, 8'hFF,         // continuation/invalid as lead
      8'hE4, 8'h41,                       // bad continuation, then 'A'
      8'hC3, 8'hF0,                       // bad continuation, new lead
      8'h80, 8'h80, 8'h80,                // ... finishing U+0000 in 4 bytes
      8'hC3                               // left open; the random chars that follow break it
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // phase 1: sender idles 23%, receiver 60%
    foreach (directed[i])
      send_byte(directed[i]);
    send_random_chars(90);

    // receiver holds off a long stretch while bytes keep coming, so the
    // block's queue fills and in_ready drops
    rx_hold_req <= 1'b1;
    send_random_chars(30);

    // sender pauses until every owed result is out
    wait_all_delivered();

    // phase 2: roles swapped
    tx_idle_pct = 60;
    rx_idle_pct = 23;
    send_random_chars(90);

    // phase 3: full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_chars(90);

    wait_all_delivered();
    repeat (10) @(posedge clk);
    if (book.due_chars.size() != 0)
      book.report_mismatch($sformatf("%0d results never came", book.due_chars.size()));

    if (book.mismatches == 0) begin
      $display("utf8_decoder_with_cjk_class regression: pass");
    end else begin
      $display("utf8_decoder_with_cjk_class regression: fail");
    end
    $finish;
  end

  // watchdog: stops a hung run and reports a fail
  initial begin
    #3_000_000;
    $display("utf8_decoder_with_cjk_class regression: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
src/utf8d_pkg.sv
src/utf8d_decode.sv
src/utf8d_outq.sv
src/utf8_decoder_with_cjk_class.sv
src/utf8d_checker.sv
bench/testbench.sv
